// ----- sv/assert_macros.svh -----
// Assertion macros shared by the escaper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent on every clock, outside reset.
`define JSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition never holds, outside reset.
`define JSU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ----- sv/jsu_pkg.sv -----
// Types, constants and helper functions of the JSON string UTF-8 escaper.
package jsu_pkg;

  typedef logic [7:0]      byte_t;
  typedef logic [3:0][7:0] quad_t;

  // UTF-8 lead ranges and second-byte limits
  localparam byte_t LEAD2_LO   = 8'hC2;
  localparam byte_t LEAD2_HI   = 8'hDF;
  localparam byte_t LEAD3_LO   = 8'hE0;
  localparam byte_t LEAD3_HI   = 8'hEF;
  localparam byte_t LEAD4_LO   = 8'hF0;
  localparam byte_t LEAD4_HI   = 8'hF4;
  localparam byte_t LEAD_ED    = 8'hED;
  localparam byte_t SEC_E0_LO  = 8'hA0;
  localparam byte_t SEC_F0_LO  = 8'h90;
  localparam byte_t CONT_MASK  = 8'hC0;
  localparam byte_t CONT_TAG   = 8'h80;
  localparam byte_t CTRL_LIMIT = 8'h20;

  // Characters of the escaped text
  localparam byte_t CH_BSL   = 8'h5C;
  localparam byte_t CH_QUOTE = 8'h22;
  localparam byte_t CH_U     = 8'h75;
  localparam byte_t CH_F     = 8'h66;
  localparam byte_t CH_D     = 8'h64;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t HEX_ALPHA_BASE = 8'h57;

  // Default depth of the token queue
  localparam int TOK_DEPTH_DEF = 4;

  // Token kinds handed from the classifier to the expander
  typedef enum logic [1:0] {
    TK_SEQ,
    TK_ESC,
    TK_CTRL,
    TK_REPL
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic       last;
    logic [1:0] cnt;
    quad_t      data;
  } tok_t;

  // Sequence length implied by a lead byte: 1 for ASCII, 0 for a bad lead.
  function automatic logic [2:0] jsu_lead_width(byte_t c);
    logic [2:0] w;
    if (c < CONT_TAG)                          w = 3'd1;
    else if (c >= LEAD2_LO && c <= LEAD2_HI)   w = 3'd2;
    else if (c >= LEAD3_LO && c <= LEAD3_HI)   w = 3'd3;
    else if (c >= LEAD4_LO && c <= LEAD4_HI)   w = 3'd4;
    else                                       w = 3'd0;
    return w;
  endfunction

  // True if the first len bytes of q can start a valid sequence.
  function automatic logic jsu_prefix_ok(quad_t q, logic [2:0] len);
    logic ok;
    ok = 1'b1;
    for (int i = 1; i < 4; i++) begin
      if (3'(i) < len && (q[i] & CONT_MASK) != CONT_TAG) ok = 1'b0;
    end
    if (len >= 3'd2) begin
      if (q[0] == LEAD3_LO && q[1] < SEC_E0_LO)  ok = 1'b0;
      if (q[0] == LEAD_ED  && q[1] >= SEC_E0_LO) ok = 1'b0;
      if (q[0] == LEAD4_LO && q[1] < SEC_F0_LO)  ok = 1'b0;
      if (q[0] == LEAD4_HI && q[1] >= SEC_F0_LO) ok = 1'b0;
    end
    return ok;
  endfunction

  // Lowercase hex digit of a nibble.
  function automatic byte_t jsu_hex(logic [3:0] n);
    byte_t ch;
    if (n < 4'd10) ch = CH_ZERO + {4'd0, n};
    else           ch = HEX_ALPHA_BASE + {4'd0, n};
    return ch;
  endfunction

endpackage

// ----- sv/jsu_tok_fifo.sv -----
// Small register queue of tokens between the classifier and the expander.
`include "assert_macros.svh"
module jsu_tok_fifo #(
  parameter int DEPTH = jsu_pkg::TOK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  jsu_pkg::tok_t push_tok_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output jsu_pkg::tok_t head_tok_o
);
  import jsu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full_o       = (cnt_r == CW'(DEPTH));
  assign head_valid_o = (cnt_r != '0);
  assign head_tok_o   = mem_r[rd_ptr_r];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store pushed tokens
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_tok_i;
  end

  `JSU_ASSERT_NEVER(a_no_push_full, push_i && full_o, "token pushed into full queue")
  `JSU_ASSERT_NEVER(a_no_pop_empty, pop_i && !head_valid_o, "token popped from empty queue")
  `JSU_ASSERT_IMP(a_ptr_match, (cnt_r == '0), (wr_ptr_r == rd_ptr_r), "empty queue pointers differ")

endmodule

// ----- sv/jsu_front.sv -----
// Front end: accepts bytes, holds UTF-8 prefixes and classifies them into tokens.
`include "assert_macros.svh"
module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          in_final_byte,
  output logic          push_o,
  output jsu_pkg::tok_t push_tok_o,
  input  logic          full_i
);
  import jsu_pkg::*;

  quad_t      wq_r, wq_nxt;
  logic [2:0] wlen_r, wlen_nxt;
  logic       wfin_r, wfin_nxt;
  logic       busy_r, busy_nxt;

  byte_t      c;
  logic [2:0] w;
  logic [2:0] used;
  logic       hold_now;
  tok_t       tk;
  quad_t      rq;
  logic [2:0] rlen;
  logic [2:0] rw;
  logic       hold_r;
  logic       step, finish, accept;
  quad_t      qn;
  logic [2:0] ln;

  // Classify the byte at the head of the working queue
  always_comb begin
    c        = wq_r[0];
    w        = jsu_lead_width(c);
    hold_now = 1'b0;
    used     = 3'd1;
    tk       = '0;
    tk.data  = wq_r;
    tk.kind  = TK_REPL;
    if (w == 3'd1) begin
      if (c < CTRL_LIMIT)                      tk.kind = TK_CTRL;
      else if (c == CH_QUOTE || c == CH_BSL)   tk.kind = TK_ESC;
      else                                     tk.kind = TK_SEQ;
    end else if (w == 3'd0) begin
      tk.kind = TK_REPL;
    end else if (w > wlen_r) begin
      if (!wfin_r && jsu_prefix_ok(wq_r, wlen_r)) hold_now = 1'b1;
      else                                       tk.kind = TK_REPL;
    end else if (jsu_prefix_ok(wq_r, w)) begin
      tk.kind = TK_SEQ;
      tk.cnt  = 2'(w - 3'd1);
      used    = w;
    end else begin
      tk.kind = TK_REPL;
    end

    // Look ahead at what remains to mark the last token of the step
    rq      = quad_t'(wq_r >> {used, 3'b000});
    rlen    = wlen_r - used;
    rw      = jsu_lead_width(rq[0]);
    hold_r  = (rlen != 3'd0) && !wfin_r && (rw > rlen) && jsu_prefix_ok(rq, rlen);
    tk.last = (rlen == 3'd0) || hold_r;
  end

  // Sequence the working queue and the input handshake
  always_comb begin
    step   = busy_r && (hold_now || !full_i);
    push_o = busy_r && !hold_now && !full_i;
    finish = step && (hold_now || tk.last);
    push_tok_o = tk;

    if (step && !hold_now) begin
      qn = rq;
      ln = rlen;
    end else begin
      qn = wq_r;
      ln = wlen_r;
    end

    in_stall = busy_r && !finish;
    accept   = in_valid && !in_stall;

    wq_nxt   = qn;
    wlen_nxt = ln;
    wfin_nxt = wfin_r;
    busy_nxt = busy_r;
    if (finish) busy_nxt = 1'b0;
    if (accept) begin
      wq_nxt[ln[1:0]] = in_byte;
      wlen_nxt        = ln + 3'd1;
      wfin_nxt        = in_final_byte;
      busy_nxt        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      wlen_r <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      wlen_r <= wlen_nxt;
    end
  end

  // Hold queue bytes and the final mark
  always_ff @(posedge clk) begin
    wq_r   <= wq_nxt;
    wfin_r <= wfin_nxt;
  end

  `JSU_ASSERT_IMP(a_busy_has_bytes, busy_r, (wlen_r != 3'd0), "busy with empty queue")
  `JSU_ASSERT_IMP(a_idle_pending_max, !busy_r, (wlen_r <= 3'd3), "too many bytes held")

endmodule

// ----- sv/jsu_back.sv -----
// Back end: expands tokens into escaped characters on a registered output.
`include "assert_macros.svh"
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid_i,
  input  jsu_pkg::tok_t head_tok_i,
  output logic          pop_o,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_char,
  output logic          out_run_end
);
  import jsu_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  byte_t      out_char_r, out_char_nxt;
  logic       out_run_end_r, out_run_end_nxt;

  byte_t      ch;
  logic [2:0] len;
  logic       at_end;
  logic       adv;

  // Pick the character at the current position of the head token
  always_comb begin
    ch  = CH_BSL;
    len = 3'd6;
    case (head_tok_i.kind)
      TK_SEQ: begin
        ch  = head_tok_i.data[idx_r[1:0]];
        len = {1'b0, head_tok_i.cnt} + 3'd1;
      end
      TK_ESC: begin
        ch  = (idx_r == 3'd0) ? CH_BSL : head_tok_i.data[0];
        len = 3'd2;
      end
      TK_CTRL: begin
        case (idx_r)
          3'd0:    ch = CH_BSL;
          3'd1:    ch = CH_U;
          3'd4:    ch = jsu_hex(head_tok_i.data[0][7:4]);
          3'd5:    ch = jsu_hex(head_tok_i.data[0][3:0]);
          default: ch = CH_ZERO;
        endcase
      end
      TK_REPL: begin
        case (idx_r)
          3'd0:    ch = CH_BSL;
          3'd1:    ch = CH_U;
          3'd5:    ch = CH_D;
          default: ch = CH_F;
        endcase
      end
      default: ch = CH_BSL;
    endcase
    at_end = (idx_r == len - 3'd1);
  end

  // Advance the output register when it is free or being taken
  always_comb begin
    adv             = !out_valid_r || !out_stall;
    pop_o           = adv && head_valid_i && at_end;
    idx_nxt         = idx_r;
    out_valid_nxt   = out_valid_r;
    out_char_nxt    = out_char_r;
    out_run_end_nxt = out_run_end_r;
    if (adv) begin
      out_valid_nxt = head_valid_i;
      if (head_valid_i) begin
        out_char_nxt    = ch;
        out_run_end_nxt = head_tok_i.last && at_end;
        idx_nxt         = at_end ? 3'd0 : idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the output beat payload
  always_ff @(posedge clk) begin
    out_char_r    <= out_char_nxt;
    out_run_end_r <= out_run_end_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign out_run_end = out_run_end_r;

  `JSU_ASSERT_IMP(a_mid_token_held, (idx_r != 3'd0), head_valid_i, "token left mid expansion")
  `JSU_ASSERT_NEVER(a_idx_range, (idx_r > 3'd5), "expansion index out of range")

endmodule

// ----- sv/json_string_utf8_escaper_unit.sv -----
// Top level: a byte from in_ is escaped to out_ beats (none while it is held as a UTF-8 prefix).
// Unstalled, plain bytes stream at one per cycle; each byte costs one classifier step per token.
// Output rate is one character per cycle while out_stall is low, set by the expander; escapes
// make 2 or 6 characters, \ufffd makes 6, and the input stalls while the token queue is full.
// Synchronous active-low reset empties the queue and drops held UTF-8 bytes; no clearing pass.
module json_string_utf8_escaper_unit #(
  parameter int TOK_DEPTH = jsu_pkg::TOK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_run_end
);
  import jsu_pkg::*;

  logic push;
  tok_t push_tok;
  logic full;
  logic pop;
  logic head_valid;
  tok_t head_tok;

  // Classify input bytes into tokens
  jsu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_final_byte (in_final_byte),
    .push_o        (push),
    .push_tok_o    (push_tok),
    .full_i        (full)
  );

  // Decouple the two sides
  jsu_tok_fifo #(
    .DEPTH (TOK_DEPTH)
  ) u_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .push_tok_i   (push_tok),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_tok_o   (head_tok)
  );

  // Expand tokens into characters
  jsu_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid_i (head_valid),
    .head_tok_i   (head_tok),
    .pop_o        (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_run_end  (out_run_end)
  );

endmodule

// ----- bench/escape_checker.sv -----
// Checker for the JSON string escaper: predicts the escaped text and compares each out_ beat.
module escape_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_final_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_char,
  input  logic       out_run_end,
  output int         fail_count,
  output int         exp_left
);
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam byte_t CH_A_LOWER = 8'h61;

  typedef struct packed {
    byte_t ch;
    logic  last;
  } esc_beat_t;

  esc_beat_t  expected_text[$];
  byte_t      held_seq [3];
  int         held_count;

  // Length of the sequence a lead byte opens: 1 for ASCII, 0 for a byte that cannot lead.
  function automatic int utf8_span(byte_t c);
    int w;
    if (c < CONT_TAG)                         w = 1;
    else if (c >= LEAD2_LO && c <= LEAD2_HI)  w = 2;
    else if (c >= LEAD3_LO && c <= LEAD3_HI)  w = 3;
    else if (c >= LEAD4_LO && c <= LEAD4_HI)  w = 4;
    else                                      w = 0;
    return w;
  endfunction

  // True if len bytes of s starting at pos can still grow into a legal sequence.
  function automatic bit can_complete(quad_t s, int pos, int len);
    bit    ok;
    int    i;
    byte_t lead;
    byte_t second;
    ok = 1'b1;
    for (i = 1; i < len; i++) begin
      if ((s[pos + i] & CONT_MASK) != CONT_TAG) ok = 1'b0;
    end
    if (len >= 2) begin
      lead   = s[pos];
      second = s[pos + 1];
      if (lead == LEAD3_LO && second < SEC_E0_LO)  ok = 1'b0;
      if (lead == LEAD_ED  && second >= SEC_E0_LO) ok = 1'b0;
      if (lead == LEAD4_LO && second < SEC_F0_LO)  ok = 1'b0;
      if (lead == LEAD4_HI && second >= SEC_F0_LO) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic byte_t hex_lower(logic [3:0] n);
    byte_t ch;
    if (n < 4'd10) ch = CH_ZERO + byte_t'(n);
    else           ch = CH_A_LOWER + byte_t'(n) - 8'd10;
    return ch;
  endfunction

  function automatic void add_char(byte_t ch);
    esc_beat_t beat;
    beat.ch   = ch;
    beat.last = 1'b0;
    expected_text.push_back(beat);
  endfunction

  function automatic void add_replacement();
    add_char(CH_BSL);
    add_char(CH_U);
    add_char(CH_F);
    add_char(CH_F);
    add_char(CH_F);
    add_char(CH_D);
  endfunction

  // Escape one accepted byte against the held prefix and queue the characters it makes final.
  function automatic void escape_byte(byte_t b, logic fin);
    quad_t work;
    byte_t c;
    int    n, pos, used, w, i, base;
    work = '0;
    for (i = 0; i < held_count; i++) work[i] = held_seq[i];
    n = held_count;
    work[n] = b;
    n++;
    held_count = 0;
    base = expected_text.size();
    pos = 0;
    while (pos < n) begin
      c = work[pos];
      w = utf8_span(c);
      used = 1;
      if (w == 1) begin
        if (c < CTRL_LIMIT) begin
          add_char(CH_BSL);
          add_char(CH_U);
          add_char(CH_ZERO);
          add_char(CH_ZERO);
          add_char(hex_lower(c[7:4]));
          add_char(hex_lower(c[3:0]));
        end else if (c == CH_QUOTE || c == CH_BSL) begin
          add_char(CH_BSL);
          add_char(c);
        end else begin
          add_char(c);
        end
      end else if (w == 0) begin
        add_replacement();
      end else if (w > n - pos) begin
        // hold an incomplete but still legal prefix, unless the string ends here
        if (!fin && can_complete(work, pos, n - pos)) begin
          for (i = 0; i < n - pos; i++) held_seq[i] = work[pos + i];
          held_count = n - pos;
          used = n - pos;
        end else begin
          add_replacement();
        end
      end else if (can_complete(work, pos, w)) begin
        for (i = 0; i < w; i++) add_char(work[pos + i]);
        used = w;
      end else begin
        add_replacement();
      end
      pos += used;
    end
    if (expected_text.size() > base) expected_text[expected_text.size() - 1].last = 1'b1;
  endfunction

  // Compare out_ beats first, then predict from the in_ beat of the same edge.
  always @(posedge clk) begin
    esc_beat_t want;
    if (!rst_n) begin
      expected_text.delete();
      held_count = 0;
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected beat char %h run_end %b", $time, out_char, out_run_end);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          if (want.ch !== out_char || want.last !== out_run_end) begin
            if (fail_count < 10)
              $display("%0t: beat mismatch: char %h run_end %b, expected char %h run_end %b",
                       $time, out_char, out_run_end, want.ch, want.last);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) escape_byte(in_byte, in_final_byte);
    end
    exp_left = expected_text.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// Top of the escaper testbench: clock, reset, byte stimulus, output stalls and the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int RANDOM_BYTES = 125;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_final_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic       out_run_end;
  int         fail_count;
  int         exp_left;
  bit         idle_on;

  logic [8:0] byte_plan[$];

  json_string_utf8_escaper_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_final_byte(in_final_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_run_end  (out_run_end)
  );

  escape_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_final_byte(in_final_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_run_end  (out_run_end),
    .fail_count   (fail_count),
    .exp_left     (exp_left)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random while idling is enabled.
  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(0, 99) < 28);
  end

  // Drive one beat with random gaps in front, then wait for its handshake.
  task automatic drive_byte(logic [8:0] beat);
    while (idle_on && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= beat[7:0];
    in_final_byte <= beat[8];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted character has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (exp_left != 0);
  endtask

  // Plan one character: mostly well-formed UTF-8 or ASCII, some broken sequences and noise.
  task automatic plan_char();
    int    pick, width, i;
    byte_t seq [4];
    logic  fin_mark;
    pick = $urandom_range(0, 99);
    fin_mark = ($urandom_range(0, 11) == 0);
    if (pick < 30) begin
      width = 1;
      seq[0] = byte_t'($urandom_range(0, 127));
    end else if (pick < 85) begin
      if (pick < 45)      width = 2;
      else if (pick < 60) width = 3;
      else if (pick < 72) width = 4;
      else                width = $urandom_range(2, 4);
      if (width == 2)      seq[0] = byte_t'($urandom_range(LEAD2_LO, LEAD2_HI));
      else if (width == 3) seq[0] = byte_t'($urandom_range(LEAD3_LO, LEAD3_HI));
      else                 seq[0] = byte_t'($urandom_range(LEAD4_LO, LEAD4_HI));
      for (i = 1; i < 4; i++) seq[i] = byte_t'($urandom_range(8'h80, 8'hBF));
      if (seq[0] == LEAD3_LO)      seq[1] = byte_t'($urandom_range(SEC_E0_LO, 8'hBF));
      else if (seq[0] == LEAD_ED)  seq[1] = byte_t'($urandom_range(8'h80, 8'h9F));
      else if (seq[0] == LEAD4_LO) seq[1] = byte_t'($urandom_range(SEC_F0_LO, 8'hBF));
      else if (seq[0] == LEAD4_HI) seq[1] = byte_t'($urandom_range(8'h80, 8'h8F));
      // cut the sequence short: either a stray byte follows or the string ends
      if (pick >= 72) begin
        width = $urandom_range(1, width - 1);
        if ($urandom_range(0, 1)) begin
          seq[width] = byte_t'($urandom);
          width++;
        end else begin
          fin_mark = 1'b1;
        end
      end
    end else begin
      width = 1;
      seq[0] = byte_t'($urandom);
    end
    for (i = 0; i < width; i++) byte_plan.push_back({fin_mark && (i == width - 1), seq[i]});
  endtask

  initial begin
    logic [8:0] opening_seq [25];
    int         i, sent;
    bit         drained;
    // controls, quote, backslash, DEL closing a string; shortest and longest two-byte forms;
    // E0 at its lower limit; ED into the surrogate range; F4 at its upper limit;
    // F0 below its limit; lone bytes; truncated sequence flushed at the end; space ending a string
    opening_seq = '{9'h000, 9'h01F, 9'h022, 9'h05C, 9'h17F,
                    9'h0C2, 9'h080, 9'h0DF, 9'h0BF,
                    9'h0E0, 9'h0A0, 9'h080,
                    9'h0ED, 9'h0A0,
                    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
                    9'h0F0, 9'h08F,
                    9'h0FF, 9'h0C1,
                    9'h0E2, 9'h182,
                    9'h120};
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_byte       = 8'h00;
    in_final_byte = 1'b0;
    idle_on       = 1'b1;
    sent          = 0;
    drained       = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < 25; i++) drive_byte(opening_seq[i]);

    // random strings; a quiet stretch with no idling in the middle
    while (sent < RANDOM_BYTES) begin
      plan_char();
      while (byte_plan.size() != 0) begin
        idle_on = !(sent >= 60 && sent < 100);
        if (!drained && sent >= 75) begin
          drain_results();
          drained = 1'b1;
        end
        drive_byte(byte_plan.pop_front());
        sent++;
      end
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && exp_left == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
